[src/prt_pkg.sv]
// ----------------------------------------------------------------------------
// prt_pkg
// shared constants, command codes and control types of the page refcount table
// ----------------------------------------------------------------------------
package prt_pkg;

    localparam int PAGE_COUNT = 4096;
    localparam int PAGE_SHIFT = 12;
    localparam int COUNT_BITS = 16;

    localparam int PAGE_BITS = $clog2(PAGE_COUNT);
    localparam int ADDR_W    = 48;
    localparam int PG_W      = ADDR_W - PAGE_SHIFT;
    localparam int ENTRY_W   = COUNT_BITS + 1;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_W     = 3;
    localparam int OUT_CNT_W = 16;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [CMD_W-1:0] CMD_TRYREF    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNREF     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CANFREE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REF       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RELLAST   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SETUSABLE = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_READY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_PAGES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USABLE_LENGTH = 2'd2;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_dp_status;

endpackage

[src/prt_ram.sv]
// ----------------------------------------------------------------------------
// prt_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/prt_ctrl.sv]
// ----------------------------------------------------------------------------
// prt_ctrl
// controller: clearing pass after reset, then accept / execute sequencing
// ----------------------------------------------------------------------------
module prt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  prt_pkg::t_dp_status i_status,
    output prt_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] ST_CLR  = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLR;
        endcase
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_cmd.clr_wr = (r_state == ST_CLR);
    assign o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.exec   = (r_state == ST_EXEC) && i_status.out_free;

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr_wr, o_cmd.load, o_cmd.exec}))
        else $error("datapath commands overlap");

    a_clr_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLR) |=> (r_state != ST_CLR))
        else $error("clearing pass re-entered without reset");

endmodule

[src/prt_dpath.sv]
// ----------------------------------------------------------------------------
// prt_dpath
// datapath: config registers, count/usable table, read-modify-write, result
// ----------------------------------------------------------------------------
module prt_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  prt_pkg::t_dp_cmd                    i_cmd,
    output prt_pkg::t_dp_status                 o_status,
    input  logic                                i_cfg_valid,
    input  logic [prt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [prt_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [prt_pkg::CMD_W-1:0]           i_in_cmd,
    input  logic [prt_pkg::ADDR_W-1:0]          i_in_address,
    input  logic                                i_in_usable_bit,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [prt_pkg::OUT_TDATA_W-1:0]     o_out_data
);

    // config registers
    logic                       r_table_ready;
    logic [prt_pkg::CFG_W-1:0]  r_memory_pages;
    logic [prt_pkg::CFG_W-1:0]  r_usable_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_ready   <= 1'b0;
            r_memory_pages  <= '0;
            r_usable_length <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prt_pkg::REG_TABLE_READY:   r_table_ready   <= i_cfg_data[0];
                prt_pkg::REG_MEMORY_PAGES:  r_memory_pages  <= i_cfg_data;
                prt_pkg::REG_USABLE_LENGTH: r_usable_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass counter
    logic [prt_pkg::PAGE_BITS-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_status.clr_last =
        (r_clr_addr == prt_pkg::PAGE_BITS'(prt_pkg::PAGE_COUNT - 1));

    // item capture
    logic [prt_pkg::PG_W-1:0]      in_page;
    logic [prt_pkg::CMD_W-1:0]     r_cmd;
    logic                          r_in_table;
    logic [prt_pkg::PAGE_BITS-1:0] r_idx;
    logic                          r_bit;

    assign in_page = i_in_address[prt_pkg::ADDR_W-1:prt_pkg::PAGE_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_in_cmd;
            r_in_table <= (in_page < prt_pkg::PG_W'(prt_pkg::PAGE_COUNT));
            r_idx      <= in_page[prt_pkg::PAGE_BITS-1:0];
            r_bit      <= i_in_usable_bit;
        end
    end

    // table: usable bit above the count
    logic                                ram_we;
    logic [prt_pkg::PAGE_BITS-1:0]       ram_waddr;
    logic [prt_pkg::ENTRY_W-1:0]         ram_wdata;
    logic [prt_pkg::ENTRY_W-1:0]         ram_rdata;

    prt_ram #(
        .WIDTH (prt_pkg::ENTRY_W),
        .DEPTH (prt_pkg::PAGE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (in_page[prt_pkg::PAGE_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    // command evaluation
    logic [prt_pkg::COUNT_BITS-1:0] c;
    logic [prt_pkg::COUNT_BITS-1:0] n_c;
    logic                           n_u;
    logic                           managed;
    logic                           ok;
    logic                           valid;
    logic                           rel;
    logic                           sat;
    logic [31:0]                    c_wide;

    always_comb begin
        c = r_in_table ? ram_rdata[prt_pkg::COUNT_BITS-1:0] : '0;
        managed = r_table_ready && r_in_table
               && (32'(r_idx) < 32'(r_memory_pages))
               && (32'(r_idx) < 32'(r_usable_length))
               && ram_rdata[prt_pkg::COUNT_BITS];
        n_c   = c;
        n_u   = ram_rdata[prt_pkg::COUNT_BITS];
        ok    = 1'b0;
        valid = r_in_table;
        rel   = 1'b0;
        sat   = 1'b0;
        unique case (r_cmd) inside
            prt_pkg::CMD_TRYREF: begin
                if (!managed) begin
                    ok = 1'b1;
                end else if (c != '0) begin
                    ok = 1'b1;
                    if (c == prt_pkg::COUNT_MAX) sat = 1'b1;
                    else n_c = c + 1'b1;
                end
            end
            prt_pkg::CMD_UNREF, prt_pkg::CMD_RELEASE: begin
                if (managed) begin
                    if (c != '0) begin
                        n_c = c - 1'b1;
                        if (r_cmd == prt_pkg::CMD_RELEASE && n_c == '0) rel = 1'b1;
                    end else begin
                        valid = 1'b0;
                    end
                end
            end
            prt_pkg::CMD_CANFREE: begin
                ok = managed && (c == '0);
            end
            prt_pkg::CMD_REF: begin
                if (r_in_table) begin
                    if (c == prt_pkg::COUNT_MAX) sat = 1'b1;
                    else n_c = c + 1'b1;
                end
            end
            prt_pkg::CMD_RELLAST: begin
                if (r_in_table && c == prt_pkg::COUNT_BITS'(1)) begin
                    n_c = '0;
                    ok  = 1'b1;
                end
            end
            prt_pkg::CMD_READ: ;
            prt_pkg::CMD_SETUSABLE: begin
                n_u = r_bit;
            end
            default: ;
        endcase
        c_wide = 32'(n_c);
    end

    // write-back, or zero fill during the clearing pass
    assign ram_we    = i_cmd.clr_wr || (i_cmd.exec && r_in_table);
    assign ram_waddr = i_cmd.clr_wr ? r_clr_addr : r_idx;
    assign ram_wdata = i_cmd.clr_wr ? '0 : {n_u, n_c};

    // result register
    logic                            r_out_valid;
    logic                            r_ok;
    logic                            r_managed;
    logic [prt_pkg::OUT_CNT_W-1:0]   r_count;
    logic                            r_count_valid;
    logic                            r_rel;
    logic                            r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok          <= ok;
            r_managed     <= managed;
            r_count       <= c_wide[prt_pkg::OUT_CNT_W-1:0];
            r_count_valid <= valid;
            r_rel         <= rel;
            r_sat         <= sat;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = {3'b000, r_sat, r_rel, r_count_valid, r_count, r_managed, r_ok};

    localparam logic [31:0] CMAX_W = 32'(prt_pkg::COUNT_MAX);

    a_rel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rel) |-> (r_count == '0 && r_managed && r_count_valid))
        else $error("frame release without count reaching zero");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sat) |-> (r_count == CMAX_W[prt_pkg::OUT_CNT_W-1:0]))
        else $error("saturation flagged below maximum count");

endmodule

[src/page_refcount_table.sv]
// ----------------------------------------------------------------------------
// page_refcount_table
// per-page reference count and usable bit table driven by command beats
// ----------------------------------------------------------------------------
// result: beat valid from the edge after the input beat is
//   accepted, later while m_axis_tready holds back the previous result
// commands: no new command is taken before the current one is written back;
//   the table read is followed by the same entry's write-back through one ram
// reset: synchronous; then a clearing pass over all PAGE_COUNT (4096) entries
//   zeroes the table with s_axis_tready low; config writes are taken throughout
// ----------------------------------------------------------------------------
module page_refcount_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [prt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [prt_pkg::CFG_W-1:0]           i_cfg_data,
    // command stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // cmd[2:0], address[50:3], usable_bit[51], zero[55:52]
    input  logic [prt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // ok[0], managed[1], count[17:2], count_valid[18], release_frame[19],
    // saturated[20], zero[23:21]
    output logic [prt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    prt_pkg::t_dp_cmd    dp_cmd;
    prt_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    prt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    prt_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_cmd        (s_axis_tdata[2:0]),
        .i_in_address    (s_axis_tdata[50:3]),
        .i_in_usable_bit (s_axis_tdata[51]),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_out_data      (m_axis_tdata)
    );

endmodule

[dv/tb_page_refcount_table.sv]
// ----------------------------------------------------------------------------
// tb_page_refcount_table
// self-checking bench for the page refcount table: command beats are mirrored
// into a software copy of the count and usable stores, and every result beat
// is compared field by field against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module tb_page_refcount_table;

    localparam int unsigned RUN_LIMIT = 1_500_000;

    typedef struct packed {
        logic                          saturated;
        logic                          release_frame;
        logic                          count_valid;
        logic [prt_pkg::OUT_CNT_W-1:0] count;
        logic                          managed;
        logic                          ok;
    } t_page_result;

    class refcount_mirror;
        logic [prt_pkg::COUNT_BITS-1:0] counts [prt_pkg::PAGE_COUNT];
        logic                           usable [prt_pkg::PAGE_COUNT];
        logic                           ready_reg;
        logic [prt_pkg::CFG_W-1:0]      mem_pages;
        logic [prt_pkg::CFG_W-1:0]      usable_len;
        t_page_result                   pending_results [$];
        int unsigned                    mismatches;

        function new();
            foreach (counts[i]) begin
                counts[i] = '0;
                usable[i] = 1'b0;
            end
            ready_reg   = 1'b0;
            mem_pages   = '0;
            usable_len  = '0;
            mismatches  = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void write_reg(input logic [prt_pkg::CFG_IDX_W-1:0] idx,
                                input logic [prt_pkg::CFG_W-1:0] val);
            case (idx)
                prt_pkg::REG_TABLE_READY:   ready_reg  = val[0];
                prt_pkg::REG_MEMORY_PAGES:  mem_pages  = val;
                prt_pkg::REG_USABLE_LENGTH: usable_len = val;
                default: ;
            endcase
        endfunction

        task report(input string field, input logic [31:0] got, input logic [31:0] want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
            mismatches++;
        endtask

        // one command beat updates the mirror and queues the result it causes
        function void note_command(input logic [prt_pkg::CMD_W-1:0] cmd,
                                   input logic [prt_pkg::ADDR_W-1:0] addr,
                                   input logic bit_in);
            logic [prt_pkg::PG_W-1:0]       page;
            logic                           in_tab;
            logic [prt_pkg::PAGE_BITS-1:0]  ix;
            logic                           mng;
            logic [prt_pkg::COUNT_BITS-1:0] c;
            t_page_result                   r;
            page   = addr[prt_pkg::ADDR_W-1:prt_pkg::PAGE_SHIFT];
            in_tab = page < prt_pkg::PG_W'(prt_pkg::PAGE_COUNT);
            ix     = page[prt_pkg::PAGE_BITS-1:0];
            mng    = ready_reg && in_tab && page < prt_pkg::PG_W'(mem_pages)
                     && page < prt_pkg::PG_W'(usable_len) && usable[ix];
            c      = in_tab ? counts[ix] : '0;
            r      = '0;
            r.managed     = mng;
            r.count_valid = in_tab;
            case (cmd)
                prt_pkg::CMD_TRYREF: begin
                    if (!mng) begin
                        r.ok = 1'b1;
                    end else if (c != '0) begin
                        r.ok = 1'b1;
                        if (c == prt_pkg::COUNT_MAX) r.saturated = 1'b1;
                        else c = c + 1'b1;
                    end
                end
                prt_pkg::CMD_UNREF, prt_pkg::CMD_RELEASE: begin
                    if (mng) begin
                        if (c != '0) begin
                            c = c - 1'b1;
                            if (cmd == prt_pkg::CMD_RELEASE && c == '0) r.release_frame = 1'b1;
                        end else begin
                            r.count_valid = 1'b0;
                        end
                    end
                end
                prt_pkg::CMD_CANFREE: r.ok = mng && c == '0;
                prt_pkg::CMD_REF: begin
                    if (in_tab) begin
                        if (c == prt_pkg::COUNT_MAX) r.saturated = 1'b1;
                        else c = c + 1'b1;
                    end
                end
                prt_pkg::CMD_RELLAST: begin
                    if (in_tab && c == prt_pkg::COUNT_BITS'(1)) begin
                        c    = '0;
                        r.ok = 1'b1;
                    end
                end
                prt_pkg::CMD_READ: ;
                prt_pkg::CMD_SETUSABLE: if (in_tab) usable[ix] = bit_in;
                default: ;
            endcase
            if (in_tab) counts[ix] = c;
            r.count = c;
            pending_results.push_back(r);
        endfunction

        task check_result(input logic [prt_pkg::OUT_TDATA_W-1:0] tdata);
            t_page_result got;
            t_page_result want;
            got = t_page_result'(tdata[$bits(t_page_result)-1:0]);
            if (pending_results.size() == 0) begin
                report("result beat with nothing outstanding", 32'(got), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok) report("ok", 32'(got.ok), 32'(want.ok));
                if (got.managed !== want.managed)
                    report("managed", 32'(got.managed), 32'(want.managed));
                if (got.count !== want.count)
                    report("count", 32'(got.count), 32'(want.count));
                if (got.count_valid !== want.count_valid)
                    report("count_valid", 32'(got.count_valid), 32'(want.count_valid));
                if (got.release_frame !== want.release_frame)
                    report("release_frame", 32'(got.release_frame), 32'(want.release_frame));
                if (got.saturated !== want.saturated)
                    report("saturated", 32'(got.saturated), 32'(want.saturated));
            end
        endtask
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [prt_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [prt_pkg::CFG_W-1:0]       i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [prt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [prt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    refcount_mirror mirror = new();
    bit             steady = 1'b0;
    int unsigned    sink_hold = 0;
    int unsigned    cycle_count = 0;

    page_refcount_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // mostly no gap, some short ones, the odd long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [prt_pkg::ADDR_W-1:0] page_addr(input int unsigned page);
        return (prt_pkg::ADDR_W'(page) << prt_pkg::PAGE_SHIFT)
               | prt_pkg::ADDR_W'($urandom_range((1 << prt_pkg::PAGE_SHIFT) - 1));
    endfunction

    // result side: take beats and stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata);
        if (sink_hold != 0) begin
            m_axis_tready <= 1'b0;
            sink_hold     <= sink_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(3) == 0) sink_hold <= gap_len();
        end
    end

    // returns at the edge the beat was taken, with tvalid still high
    task automatic send_cmd(input logic [prt_pkg::CMD_W-1:0] cmd,
                            input logic [prt_pkg::ADDR_W-1:0] addr,
                            input logic bit_in);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(prt_pkg::IN_TDATA_W - prt_pkg::CMD_W - prt_pkg::ADDR_W - 1){1'b0}},
                          bit_in, addr, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        mirror.note_command(cmd, addr, bit_in);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic rdy, input logic [prt_pkg::CFG_W-1:0] mem,
                              input logic [prt_pkg::CFG_W-1:0] len);
        logic [prt_pkg::CFG_IDX_W-1:0] regs [3];
        logic [prt_pkg::CFG_W-1:0]     vals [3];
        int                            i;
        regs = '{prt_pkg::REG_TABLE_READY, prt_pkg::REG_MEMORY_PAGES,
                 prt_pkg::REG_USABLE_LENGTH};
        vals = '{prt_pkg::CFG_W'(rdy), mem, len};
        for (i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            mirror.write_reg(regs[i], vals[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random();
        int unsigned                sel;
        int unsigned                page;
        logic [prt_pkg::CMD_W-1:0]  cmd;
        logic [prt_pkg::ADDR_W-1:0] addr;
        sel = $urandom_range(99);
        if (sel < 65) begin
            page = $urandom_range(15);
        end else if (sel < 75) begin
            // pages either side of the register limits, or the last page of the table
            case ($urandom_range(4))
                0: page = 32'(mirror.mem_pages) - 1;
                1: page = 32'(mirror.mem_pages);
                2: page = 32'(mirror.usable_len) - 1;
                3: page = 32'(mirror.usable_len);
                default: page = prt_pkg::PAGE_COUNT - 1;
            endcase
        end else if (sel < 88) begin
            page = $urandom_range(prt_pkg::PAGE_COUNT - 1);
        end else begin
            page = 32'hFFFF_FFFF;
        end
        if (page < (1 << prt_pkg::CFG_W)) begin
            addr = page_addr(page);
        end else begin
            addr = prt_pkg::ADDR_W'({$urandom, $urandom});
            if (addr[prt_pkg::ADDR_W-1:prt_pkg::PAGE_SHIFT+prt_pkg::PAGE_BITS] == '0)
                addr[prt_pkg::PAGE_SHIFT+prt_pkg::PAGE_BITS] = 1'b1;
        end
        sel = $urandom_range(99);
        if (sel < 22)      cmd = prt_pkg::CMD_REF;
        else if (sel < 36) cmd = prt_pkg::CMD_TRYREF;
        else if (sel < 48) cmd = prt_pkg::CMD_UNREF;
        else if (sel < 62) cmd = prt_pkg::CMD_RELEASE;
        else if (sel < 70) cmd = prt_pkg::CMD_CANFREE;
        else if (sel < 78) cmd = prt_pkg::CMD_RELLAST;
        else if (sel < 85) cmd = prt_pkg::CMD_READ;
        else               cmd = prt_pkg::CMD_SETUSABLE;
        send_cmd(cmd, addr, $urandom_range(9) < 7);
    endtask

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [prt_pkg::ADDR_W-1:0] top_in_table;
        int                         ph;
        top_in_table = (prt_pkg::ADDR_W'(prt_pkg::PAGE_COUNT) << prt_pkg::PAGE_SHIFT) - 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // table not ready: nothing is managed, ref and setusable still act
        set_config(1'b0, 13'd4096, 13'd4096);
        send_cmd(prt_pkg::CMD_TRYREF, page_addr(5), 1'b0);
        send_cmd(prt_pkg::CMD_SETUSABLE, page_addr(5), 1'b1);
        send_cmd(prt_pkg::CMD_REF, page_addr(5), 1'b0);
        send_cmd(prt_pkg::CMD_CANFREE, page_addr(5), 1'b0);
        send_cmd(prt_pkg::CMD_UNREF, page_addr(5), 1'b0);
        drain();

        set_config(1'b1, 13'd4096, 13'd4096);
        send_cmd(prt_pkg::CMD_SETUSABLE, '0, 1'b1);
        send_cmd(prt_pkg::CMD_SETUSABLE, top_in_table, 1'b1);
        send_cmd(prt_pkg::CMD_CANFREE, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_TRYREF, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_UNREF, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_RELEASE, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_REF, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_TRYREF, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_RELEASE, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_RELEASE, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_REF, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_RELLAST, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_RELLAST, page_addr(0), 1'b0);
        send_cmd(prt_pkg::CMD_REF, top_in_table, 1'b0);
        send_cmd(prt_pkg::CMD_UNREF, top_in_table, 1'b0);
        send_cmd(prt_pkg::CMD_TRYREF, page_addr(5), 1'b0);
        // indices beyond the table
        send_cmd(prt_pkg::CMD_REF, '1, 1'b1);
        send_cmd(prt_pkg::CMD_RELLAST, '1, 1'b0);
        send_cmd(prt_pkg::CMD_SETUSABLE, '1, 1'b1);
        send_cmd(prt_pkg::CMD_TRYREF, page_addr(prt_pkg::PAGE_COUNT), 1'b0);
        send_cmd(prt_pkg::CMD_READ, page_addr(prt_pkg::PAGE_COUNT), 1'b0);
        send_cmd(prt_pkg::CMD_SETUSABLE, page_addr(5), 1'b0);
        send_cmd(prt_pkg::CMD_CANFREE, page_addr(5), 1'b0);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(1'b1, 13'd4096, 13'd4096);
                1: set_config(1'b1, 13'd8, 13'd4096);
                2: set_config(1'b1, 13'd4096, 13'd12);
                3: set_config(1'b0, 13'd4096, 13'd4096);
                4: set_config(1'b1, 13'd0, 13'd0);
                5: set_config(1'b1, 13'h1FFF, 13'h1FFF);
                6: set_config(1'($urandom_range(1)),
                              prt_pkg::CFG_W'($urandom_range(4096)),
                              prt_pkg::CFG_W'($urandom_range(4096)));
                default: set_config(1'b1, 13'd4096, 13'd4096);
            endcase
            steady = (ph == 3);
            repeat (150) send_random();
            drain();
        end
        steady = 1'b0;

        repeat (8) @(posedge i_clk);
        if (mirror.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
